// File: rtl/core/mpq_pkg.sv
// Package for the min priority queue core: sizes, command and status codes,
// word types and the controller/datapath link types. No dependencies.
`default_nettype none

package mpq_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int KEY_W    = 32;
	localparam int OCC_W    = 7;

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_FIND    = 2'd1,
		CMD_EXTRACT = 2'd2
	} cmd_e;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_e;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_MOVE,
		S_DONE
	} state_e;

	typedef struct packed {
		logic [1:0]              cmd;
		logic signed [KEY_W-1:0] key;
	} in_word_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [KEY_W-1:0] min_key;
		logic [OCC_W-1:0]        occupancy;
	} out_word_t;

	// controller -> datapath
	typedef struct packed {
		logic       do_insert;
		logic       scan_start;
		logic       scan_rd;
		logic       move_rd;
		logic       move_wr;
		logic       load_res;
		logic [1:0] res_status;
		logic       res_use_min;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic full;
		logic scan_last;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/mpq_ctrl.sv
// Controller of the min priority queue: command decode and scan sequencing.
// Depends on mpq_pkg.
`default_nettype none

module mpq_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cmd_valid,
	output logic               cmd_ready,
	input  mpq_pkg::in_word_t  cmd_word,
	input  mpq_pkg::dp_stat_t  stat,
	output mpq_pkg::ctrl_cmd_t ctl
);
	import mpq_pkg::*;

	state_e state_q;
	state_e state_d;
	logic   extract_q;
	logic   accept;
	logic   is_search;

	assign cmd_ready = (state_q == S_IDLE) && stat.out_free;
	assign accept    = cmd_valid && cmd_ready;
	assign is_search = cmd_word.cmd inside {CMD_FIND, CMD_EXTRACT};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			extract_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				extract_q <= (cmd_word.cmd == CMD_EXTRACT);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && is_search && !stat.empty)
					state_d = S_SCAN;
			end
			S_SCAN: begin
				if (stat.scan_last)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = extract_q ? S_MOVE : S_DONE;
			end
			S_MOVE: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.res_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd_word.cmd)
						CMD_INSERT: begin
							ctl.load_res = 1'b1;
							if (stat.full) begin
								ctl.res_status = ST_FULL;
							end else begin
								ctl.do_insert = 1'b1;
							end
						end
						CMD_FIND, CMD_EXTRACT: begin
							if (stat.empty) begin
								ctl.load_res   = 1'b1;
								ctl.res_status = ST_EMPTY;
							end else begin
								ctl.scan_start = 1'b1;
							end
						end
						default: begin
							// unused code: plain ok word, queue untouched
							ctl.load_res = 1'b1;
						end
					endcase
				end
			end
			S_SCAN: begin
				ctl.scan_rd = 1'b1;
			end
			S_DRAIN: begin
				// last compare happens here; fetch the tail key for an extract
				ctl.move_rd = extract_q;
			end
			S_MOVE: begin
				ctl.move_wr = 1'b1;
			end
			S_DONE: begin
				ctl.load_res    = stat.out_free;
				ctl.res_use_min = 1'b1;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/mpq_dpath.sv
// Datapath of the min priority queue: key memory, count, minimum tracker
// and result register. Depends on mpq_pkg.
`default_nettype none

module mpq_dpath (
	input  wire                clk,
	input  wire                arst_n,
	input  mpq_pkg::in_word_t  cmd_word,
	input  mpq_pkg::ctrl_cmd_t ctl,
	input  wire                res_ready,
	output logic               res_valid,
	output mpq_pkg::out_word_t res_word,
	output mpq_pkg::dp_stat_t  stat
);
	import mpq_pkg::*;

	logic signed [KEY_W-1:0] mem [CAPACITY];

	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        rd_idx_q;
	logic [IDX_W-1:0]        rd_addr;
	logic [IDX_W-1:0]        last_idx;
	logic signed [KEY_W-1:0] rd_data_s1;
	logic [IDX_W-1:0]        rd_slot_s1;
	logic                    rdv_s1;
	logic signed [KEY_W-1:0] best_key_q;
	logic [IDX_W-1:0]        best_slot_q;
	logic                    best_valid_q;
	logic                    take;
	logic [CNT_W-1:0]        occ_next;
	logic                    res_valid_q;
	out_word_t               res_word_q;

	assign last_idx = IDX_W'(count_q - CNT_W'(1));
	assign rd_addr  = ctl.move_rd ? last_idx : rd_idx_q;
	assign take     = rdv_s1 && (!best_valid_q || (rd_data_s1 < best_key_q));
	assign occ_next = ctl.do_insert ? count_q + CNT_W'(1) : count_q;

	always_ff @(posedge clk) begin
		if (ctl.do_insert)
			mem[count_q[IDX_W-1:0]] <= cmd_word.key;
		else if (ctl.move_wr)
			mem[best_slot_q] <= rd_data_s1;
		if (ctl.scan_rd || ctl.move_rd) begin
			rd_data_s1 <= mem[rd_addr];
			rd_slot_s1 <= rd_addr;
		end
		if (take) begin
			best_key_q  <= rd_data_s1;
			best_slot_q <= rd_slot_s1;
		end
		if (ctl.load_res) begin
			res_word_q.status    <= ctl.res_status;
			res_word_q.min_key   <= ctl.res_use_min ? best_key_q : '0;
			res_word_q.occupancy <= OCC_W'(occ_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			rd_idx_q     <= '0;
			rdv_s1       <= 1'b0;
			best_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (ctl.do_insert)
				count_q <= count_q + CNT_W'(1);
			else if (ctl.move_wr)
				count_q <= count_q - CNT_W'(1);

			if (ctl.scan_start)
				rd_idx_q <= '0;
			else if (ctl.scan_rd)
				rd_idx_q <= rd_idx_q + IDX_W'(1);

			rdv_s1 <= ctl.scan_rd;

			if (ctl.scan_start)
				best_valid_q <= 1'b0;
			else if (take)
				best_valid_q <= 1'b1;

			if (ctl.load_res)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	assign res_valid      = res_valid_q;
	assign res_word       = res_word_q;

	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q >= CNT_W'(CAPACITY));
	assign stat.scan_last = (CNT_W'(rd_idx_q) == count_q - CNT_W'(1));
	assign stat.out_free  = !res_valid_q || res_ready;

endmodule

`default_nettype wire

// File: rtl/core/min_priority_queue_core.sv
// Top level of the min priority queue: controller plus datapath.
// Depends on mpq_pkg, mpq_ctrl, mpq_dpath.
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+-----------------------------
//   cmd     | in        | cmd_valid / cmd_ready | cmd, key
//   res     | out       | res_valid / res_ready | status, min_key, occupancy
//
// Insert, unused codes and commands on an empty queue are answered from idle.
// Find and extract run a linear scan over the keys held, through the single
// read port of the key memory; extract then moves the tail key into the hole.
// One command at a time; cmd_ready drops while a result waits and cannot
// leave, and a registered result word parts the two sides.
// Reset clears the count and control state; the key memory is not cleared.
`default_nettype none

module min_priority_queue_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cmd_valid,
	output logic               cmd_ready,
	input  mpq_pkg::in_word_t  cmd_word,
	output logic               res_valid,
	input  wire                res_ready,
	output mpq_pkg::out_word_t res_word
);
	import mpq_pkg::*;

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	mpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_word  (cmd_word),
		.stat      (stat),
		.ctl       (ctl)
	);

	mpq_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_word  (cmd_word),
		.ctl       (ctl),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res_word  (res_word),
		.stat      (stat)
	);

endmodule

`default_nettype wire

// File: rtl/core/mpq_checker.sv
// Port-level checks for the min priority queue core, bound to the top level.
// Depends on mpq_pkg and min_priority_queue_core.
`default_nettype none

module mpq_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                cmd_valid,
	input wire                cmd_ready,
	input mpq_pkg::in_word_t  cmd_word,
	input wire                res_valid,
	input wire                res_ready,
	input mpq_pkg::out_word_t res_word
);
	import mpq_pkg::*;

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_word))
		else $error("command word changed while waiting");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_word))
		else $error("result word changed while stalled");

	a_zero_key: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_word.status != ST_OK) |-> res_word.min_key == '0)
		else $error("non-ok word carries a key");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_word.status == ST_FULL) |->
			res_word.occupancy == OCC_W'(CAPACITY))
		else $error("full status below capacity");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_word.status == ST_EMPTY) |-> res_word.occupancy == '0)
		else $error("empty status with keys held");

endmodule

bind min_priority_queue_core mpq_checker u_mpq_checker (.*);

`default_nettype wire
